>>> sv/wavetable_oscillator_linear_interp_defines.svh
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shared assertion wrappers; build with NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WTOSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wtosc: assertion failed");
`define WTOSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("wtosc: invariant failed");
`else
`define WTOSC_ASSERT(lbl, prop)
`define WTOSC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> sv/wtosc_pkg.sv
// ----------------------------------------------------------------------------
// wtosc_pkg
// Types and fixed widths of the wavetable oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package wtosc_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned PhaseBits  = 27;
  localparam int unsigned IntBits    = PhaseBits - FracBits;
  localparam int unsigned AmpBits    = 16;
  localparam int unsigned AmpFrac    = 14;
  localparam int unsigned LenBits    = 12;
  localparam int unsigned IdxBits    = 11;
  localparam int unsigned CfgBits    = PhaseBits;
  localparam int unsigned MulBits    = SampleBits + 1;
  localparam int unsigned ProdBits   = 2 * MulBits;
  localparam int unsigned CntBits    = $clog2(IntBits);
  localparam int unsigned InDataBits = 40;

  localparam logic [AmpBits-1:0] AmpReset = AmpBits'(16384);

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_COMMIT    = 2'd2,
    CMD_PHASE_RST = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_PHASE_INC = 1'b0,
    CFG_AMPLITUDE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_A,
    ST_RD_B,
    ST_LATCH_B,
    ST_MUL_F,
    ST_INTERP,
    ST_MUL_AMP,
    ST_SAT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

>>> sv/wavetable_oscillator_linear_interp.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_linear_interp
// Double-buffered wavetable oscillator with linear interpolation, Q2.14 gain
// and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage: write, commit and phase-reset words take effect when accepted. For a
// tick word the phase integer part is reduced modulo the active length by a
// restoring divider, one quotient bit per cycle, then the two table reads
// share the RAM read port and one 17x17 multiplier does the interpolation
// and the gain in turn. A tick with an empty active table skips the divider
// and the reads. The input side is not ready while a tick is being worked;
// a finished sample sits in the output register and the next word is taken
// while it waits. Table writes go to the bank not being played; a commit
// swaps banks at the next tick, and any write cancels a pending commit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wavetable_oscillator_linear_interp_defines.svh"

module wavetable_oscillator_linear_interp #(
  parameter int unsigned TABLE_DEPTH = 2048
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // entry_index, entry_value, table_length, zero pad
  input  wire logic [wtosc_pkg::InDataBits-1:0]       s_axis_tdata,
  // cmd
  input  wire logic [1:0]                             s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // sample_out
  output logic      [wtosc_pkg::SampleBits-1:0]       m_axis_tdata,
  input  wire logic                                   cfg_we_i,
  input  wire logic [0:0]                             cfg_index_i,
  input  wire logic [wtosc_pkg::CfgBits-1:0]          cfg_data_i
);

  localparam int unsigned AddrBits = $clog2(TABLE_DEPTH);
  localparam int unsigned SB = wtosc_pkg::SampleBits;
  localparam int unsigned FB = wtosc_pkg::FracBits;
  localparam int unsigned IB = wtosc_pkg::IntBits;
  localparam int unsigned LB = wtosc_pkg::LenBits;
  localparam int unsigned MB = wtosc_pkg::MulBits;
  localparam int unsigned PB = wtosc_pkg::ProdBits;
  localparam int unsigned PhB = wtosc_pkg::PhaseBits;
  localparam logic signed [PB-1:0] SatHi = PB'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [PB-1:0] SatLo = -SatHi - PB'(1);

  // input unpack
  wtosc_pkg::cmd_e                cmd;
  logic [wtosc_pkg::IdxBits-1:0]  entry_index;
  logic signed [SB-1:0]           entry_value;
  logic [LB-1:0]                  table_length;

  assign cmd          = wtosc_pkg::cmd_e'(s_axis_tuser);
  assign entry_index  = s_axis_tdata[10:0];
  assign entry_value  = s_axis_tdata[26:11];
  assign table_length = s_axis_tdata[38:27];

  // state
  wtosc_pkg::state_e state_q, state_d;

  logic [PhB-1:0]                 inc_q;
  logic [wtosc_pkg::AmpBits-1:0]  amp_q;
  logic                           bank_q;
  logic [LB-1:0]                  act_len_q;
  logic [LB-1:0]                  pend_len_q;
  logic                           swap_q;
  logic [PhB-1:0]                 phase_q;
  logic [IB-1:0]                  quo_q;
  logic [IB-1:0]                  rem_q;
  logic [wtosc_pkg::CntBits-1:0]  cnt_q;
  logic signed [SB-1:0]           a_q, b_q, interp_q, res_q;
  logic signed [PB-1:0]           prod_q;
  logic                           m_valid_q;
  logic [SB-1:0]                  m_data_q;

  logic            s_acc, out_free, ram_we, in_range;
  logic [LB-1:0]   len_eff, len_sat;
  logic [LB:0]     rem_try;
  logic [IB-1:0]   rem_d;
  logic [LB-1:0]   j_full, j_idx;
  logic [AddrBits-1:0] raddr;
  logic [SB-1:0]   rd_a, rd_b, rdata;
  logic signed [MB-1:0] mul_x, mul_y;
  logic signed [PB-1:0] prod;
  logic signed [PB-1:0] scaled;
  logic signed [SB-1:0] sat_d, interp_d;
  logic [PhB-1:0]  phase_d;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign len_eff  = swap_q ? pend_len_q : act_len_q;
  assign len_sat  = (32'(table_length) > 32'(TABLE_DEPTH)) ? LB'(TABLE_DEPTH) : table_length;
  assign in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

  // divider step: remainder of phase integer part by active length
  always_comb begin
    rem_try = {1'b0, rem_q, quo_q[IB-1]};
    if (rem_try >= {1'b0, act_len_q}) begin
      rem_try = rem_try - {1'b0, act_len_q};
    end
    rem_d = rem_try[IB-1:0];
  end

  assign j_full = LB'(rem_q) + LB'(1);
  assign j_idx  = (j_full >= act_len_q) ? '0 : j_full;

  // shared multiplier
  assign prod = PB'(mul_x) * PB'(mul_y);

  always_comb begin
    interp_d = SB'(MB'(a_q) + MB'(prod_q >>> FB));
    scaled   = prod_q >>> wtosc_pkg::AmpFrac;
    if (scaled > SatHi) begin
      sat_d = SatHi[SB-1:0];
    end else if (scaled < SatLo) begin
      sat_d = SatLo[SB-1:0];
    end else begin
      sat_d = scaled[SB-1:0];
    end
    phase_d = {rem_q, phase_q[FB-1:0]} + inc_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wtosc_pkg::ST_IDLE: begin
        if (s_acc && (cmd == wtosc_pkg::CMD_TICK)) begin
          state_d = (len_eff == '0) ? wtosc_pkg::ST_OUT : wtosc_pkg::ST_MOD;
        end
      end
      wtosc_pkg::ST_MOD: begin
        if (cnt_q == '0) begin
          state_d = wtosc_pkg::ST_RD_A;
        end
      end
      wtosc_pkg::ST_RD_A:    state_d = wtosc_pkg::ST_RD_B;
      wtosc_pkg::ST_RD_B:    state_d = wtosc_pkg::ST_LATCH_B;
      wtosc_pkg::ST_LATCH_B: state_d = wtosc_pkg::ST_MUL_F;
      wtosc_pkg::ST_MUL_F:   state_d = wtosc_pkg::ST_INTERP;
      wtosc_pkg::ST_INTERP:  state_d = wtosc_pkg::ST_MUL_AMP;
      wtosc_pkg::ST_MUL_AMP: state_d = wtosc_pkg::ST_SAT;
      wtosc_pkg::ST_SAT:     state_d = wtosc_pkg::ST_OUT;
      wtosc_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = wtosc_pkg::ST_IDLE;
        end
      end
      default: state_d = wtosc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    raddr         = AddrBits'(j_idx);
    mul_x         = MB'(b_q) - MB'(a_q);
    mul_y         = MB'($signed({1'b0, phase_q[FB-1:0]}));
    case (state_q)
      wtosc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = s_axis_tvalid && (cmd == wtosc_pkg::CMD_WRITE) && in_range;
      end
      wtosc_pkg::ST_RD_A: begin
        raddr = AddrBits'(rem_q);
      end
      wtosc_pkg::ST_MUL_AMP: begin
        mul_x = MB'(interp_q);
        mul_y = MB'($signed({1'b0, amp_q}));
      end
      default: begin
      end
    endcase
  end

  // table banks; writes go to the bank not being played
  wtosc_ram #(.Width(SB), .Depth(TABLE_DEPTH)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (ram_we && bank_q),
    .waddr_i (AddrBits'(entry_index)),
    .wdata_i (entry_value),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  wtosc_ram #(.Width(SB), .Depth(TABLE_DEPTH)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (ram_we && !bank_q),
    .waddr_i (AddrBits'(entry_index)),
    .wdata_i (entry_value),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  assign rdata = bank_q ? rd_b : rd_a;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wtosc_pkg::ST_IDLE;
      inc_q      <= '0;
      amp_q      <= wtosc_pkg::AmpReset;
      bank_q     <= 1'b0;
      act_len_q  <= '0;
      pend_len_q <= '0;
      swap_q     <= 1'b0;
      phase_q    <= '0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (wtosc_pkg::cfg_idx_e'(cfg_index_i))
          wtosc_pkg::CFG_PHASE_INC: inc_q <= cfg_data_i;
          wtosc_pkg::CFG_AMPLITUDE: amp_q <= cfg_data_i[wtosc_pkg::AmpBits-1:0];
          default: begin
          end
        endcase
      end
      if ((state_q == wtosc_pkg::ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        wtosc_pkg::ST_IDLE: begin
          if (s_acc) begin
            case (cmd)
              wtosc_pkg::CMD_WRITE: swap_q <= 1'b0;
              wtosc_pkg::CMD_COMMIT: begin
                pend_len_q <= len_sat;
                swap_q     <= 1'b1;
              end
              wtosc_pkg::CMD_PHASE_RST: phase_q <= '0;
              wtosc_pkg::CMD_TICK: begin
                if (swap_q) begin
                  bank_q    <= !bank_q;
                  act_len_q <= pend_len_q;
                  swap_q    <= 1'b0;
                end
                cnt_q <= wtosc_pkg::CntBits'(IB - 1);
                if (len_eff == '0) begin
                  phase_q <= phase_q + inc_q;
                end
              end
              default: begin
              end
            endcase
          end
        end
        wtosc_pkg::ST_MOD: begin
          cnt_q <= cnt_q - wtosc_pkg::CntBits'(1);
        end
        wtosc_pkg::ST_SAT: begin
          phase_q <= phase_d;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      wtosc_pkg::ST_IDLE: begin
        quo_q <= phase_q[PhB-1:FB];
        rem_q <= '0;
        res_q <= '0;
      end
      wtosc_pkg::ST_MOD: begin
        quo_q <= {quo_q[IB-2:0], 1'b0};
        rem_q <= rem_d;
      end
      wtosc_pkg::ST_RD_B:    a_q      <= rdata;
      wtosc_pkg::ST_LATCH_B: b_q      <= rdata;
      wtosc_pkg::ST_MUL_F:   prod_q   <= prod;
      wtosc_pkg::ST_INTERP:  interp_q <= interp_d;
      wtosc_pkg::ST_MUL_AMP: prod_q   <= prod;
      wtosc_pkg::ST_SAT:     res_q    <= sat_d;
      wtosc_pkg::ST_OUT: begin
        if (out_free) begin
          m_data_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `WTOSC_ASSERT(a_rem_below_len, (state_q == wtosc_pkg::ST_RD_A) |-> (LB'(rem_q) < act_len_q))
  `WTOSC_ASSERT(a_mod_needs_len, (state_q == wtosc_pkg::ST_MOD) |-> (act_len_q != '0))
  `WTOSC_ASSERT(a_tick_clears_swap, (s_acc && (cmd == wtosc_pkg::CMD_TICK)) |=> !swap_q)
  `WTOSC_ASSERT(a_out_from_seq, $rose(m_valid_q) |-> ($past(state_q) == wtosc_pkg::ST_OUT))
  `WTOSC_ASSERT_ALWAYS(a_len_bound, 32'(act_len_q) <= 32'(TABLE_DEPTH))

endmodule

`default_nettype wire

>>> sv/wtosc_ram.sv
// ----------------------------------------------------------------------------
// wtosc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wtosc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> bench/wavetable_oscillator_linear_interp_tb.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_linear_interp_tb
// Drives command words into the oscillator stream port and checks every
// output sample against a bit-exact software copy of the oscillator: bank
// swap on commit, modulo phase, linear interpolation, Q2.14 gain and
// saturation. A short directed run hits the corner cases. Then several random
// phases run with varying gaps, back-pressure and register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_linear_interp_tb;

  localparam int TableDepth = 2048;
  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 400;

  class osc_sample_tracker;
    logic signed [wtosc_pkg::SampleBits-1:0] tbl [2][TableDepth];
    bit                                      seen [2][TableDepth];
    bit                                      act;
    logic [wtosc_pkg::LenBits-1:0]           act_len;
    logic [wtosc_pkg::LenBits-1:0]           pend_len;
    bit                                      swap_wait;
    logic [wtosc_pkg::PhaseBits-1:0]         phase;
    logic [wtosc_pkg::PhaseBits-1:0]         inc;
    logic [wtosc_pkg::AmpBits-1:0]           amp;
    logic [wtosc_pkg::SampleBits-1:0]        samples_due [$];
    int                                      errors;

    function new();
      act = 1'b0;
      act_len = '0;
      pend_len = '0;
      swap_wait = 1'b0;
      phase = '0;
      inc = '0;
      amp = wtosc_pkg::AmpReset;
      errors = 0;
    endfunction

    function void set_reg(wtosc_pkg::cfg_idx_e r, logic [wtosc_pkg::CfgBits-1:0] v);
      if (r == wtosc_pkg::CFG_PHASE_INC) inc = v;
      else amp = v[wtosc_pkg::AmpBits-1:0];
    endfunction

    // true when the next tick reads only entries that hold data
    function bit tick_is_defined();
      bit                            bk;
      logic [wtosc_pkg::LenBits-1:0] len;
      longint                        ph, i, j;
      bk = swap_wait ? ~act : act;
      len = swap_wait ? pend_len : act_len;
      if (len == 0) return 1'b1;
      ph = longint'(phase) % (longint'(len) << wtosc_pkg::FracBits);
      i = ph >> wtosc_pkg::FracBits;
      j = i + 1;
      if (j >= len) j = 0;
      return seen[bk][i] && seen[bk][j];
    endfunction

    function void next_sample();
      longint                           ph, i, j, f, a, b, acc;
      logic [wtosc_pkg::SampleBits-1:0] res;
      if (swap_wait) begin
        act = ~act;
        act_len = pend_len;
        swap_wait = 1'b0;
      end
      ph = phase;
      res = '0;
      if (act_len != 0) begin
        ph = ph % (longint'(act_len) << wtosc_pkg::FracBits);
        i = ph >> wtosc_pkg::FracBits;
        f = ph & ((longint'(1) << wtosc_pkg::FracBits) - 1);
        j = i + 1;
        if (j >= act_len) j = 0;
        a = tbl[act][i];
        b = tbl[act][j];
        acc = (a * ((longint'(1) << wtosc_pkg::FracBits) - f) + b * f)
              >>> wtosc_pkg::FracBits;
        acc = (acc * longint'(amp)) >>> wtosc_pkg::AmpFrac;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        res = acc[wtosc_pkg::SampleBits-1:0];
      end
      phase = wtosc_pkg::PhaseBits'(ph + inc);
      samples_due.push_back(res);
    endfunction

    function void note_word(wtosc_pkg::cmd_e c, logic [wtosc_pkg::InDataBits-1:0] d);
      logic [wtosc_pkg::IdxBits-1:0] idx;
      logic [wtosc_pkg::LenBits-1:0] len;
      idx = d[wtosc_pkg::IdxBits-1:0];
      len = d[wtosc_pkg::IdxBits+wtosc_pkg::SampleBits +: wtosc_pkg::LenBits];
      case (c)
        wtosc_pkg::CMD_WRITE: begin
          tbl[~act][idx] = d[wtosc_pkg::IdxBits +: wtosc_pkg::SampleBits];
          seen[~act][idx] = 1'b1;
          swap_wait = 1'b0;
        end
        wtosc_pkg::CMD_COMMIT: begin
          pend_len = (len > TableDepth) ? wtosc_pkg::LenBits'(TableDepth) : len;
          swap_wait = 1'b1;
        end
        wtosc_pkg::CMD_PHASE_RST: phase = '0;
        default: next_sample();
      endcase
    endfunction

    function void check_sample(logic [wtosc_pkg::SampleBits-1:0] d);
      logic [wtosc_pkg::SampleBits-1:0] want;
      if (samples_due.size() == 0) begin
        $display("%0t unexpected sample: expected none, got %0d", $time, $signed(d));
        errors++;
      end else begin
        want = samples_due.pop_front();
        if (want !== d) begin
          $display("%0t sample mismatch: expected %0d, got %0d", $time,
                   $signed(want), $signed(d));
          errors++;
        end
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  // entry_index, entry_value, table_length, zero pad
  logic [wtosc_pkg::InDataBits-1:0] s_axis_tdata;
  // cmd
  logic [1:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // sample_out
  logic [wtosc_pkg::SampleBits-1:0] m_axis_tdata;
  logic                             cfg_we_i;
  logic [0:0]                       cfg_index_i;
  logic [wtosc_pkg::CfgBits-1:0]    cfg_data_i;

  osc_sample_tracker osc;
  int                src_idle_pct = 0;
  int                rx_stall_pct = 0;
  bit                rx_hold_req = 1'b0;
  int                sent_words = 0;

  wavetable_oscillator_linear_interp #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) osc.check_sample(m_axis_tdata);
      if (rx_hold_req) begin
        hold_left = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send(wtosc_pkg::cmd_e c, logic [wtosc_pkg::IdxBits-1:0] idx,
                      logic [wtosc_pkg::SampleBits-1:0] val,
                      logic [wtosc_pkg::LenBits-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c;
    s_axis_tdata <= {1'b0, len, val, idx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    osc.note_word(c, s_axis_tdata);
    sent_words++;
  endtask

  function automatic logic [wtosc_pkg::SampleBits-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return wtosc_pkg::SampleBits'($urandom);
    endcase
  endfunction

  task automatic write_entry(logic [wtosc_pkg::IdxBits-1:0] idx,
                             logic [wtosc_pkg::SampleBits-1:0] val);
    send(wtosc_pkg::CMD_WRITE, idx, val, wtosc_pkg::LenBits'($urandom));
  endtask

  task automatic commit(logic [wtosc_pkg::LenBits-1:0] len);
    send(wtosc_pkg::CMD_COMMIT, wtosc_pkg::IdxBits'($urandom),
         wtosc_pkg::SampleBits'($urandom), len);
  endtask

  task automatic phase_reset();
    send(wtosc_pkg::CMD_PHASE_RST, wtosc_pkg::IdxBits'($urandom),
         wtosc_pkg::SampleBits'($urandom), wtosc_pkg::LenBits'($urandom));
  endtask

  task automatic tick();
    if (osc.tick_is_defined())
      send(wtosc_pkg::CMD_TICK, wtosc_pkg::IdxBits'($urandom),
           wtosc_pkg::SampleBits'($urandom), wtosc_pkg::LenBits'($urandom));
  endtask

  task automatic load_table(int n, logic [wtosc_pkg::LenBits-1:0] len);
    for (int k = 0; k < n; k++) write_entry(wtosc_pkg::IdxBits'(k), pick_value());
    commit(len);
  endtask

  // wait until every sample is back and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (osc.samples_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [wtosc_pkg::PhaseBits-1:0] step,
                            logic [wtosc_pkg::AmpBits-1:0] gain);
    cfg_we_i <= 1'b1;
    cfg_index_i <= wtosc_pkg::CFG_PHASE_INC;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_index_i <= wtosc_pkg::CFG_AMPLITUDE;
    cfg_data_i <= wtosc_pkg::CfgBits'(gain);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    osc.set_reg(wtosc_pkg::CFG_PHASE_INC, step);
    osc.set_reg(wtosc_pkg::CFG_AMPLITUDE, wtosc_pkg::CfgBits'(gain));
  endtask

  task automatic random_config();
    logic [wtosc_pkg::PhaseBits-1:0] step;
    logic [wtosc_pkg::AmpBits-1:0]   gain;
    case ($urandom_range(5))
      0: step = '0;
      1: step = '1;
      2: step = wtosc_pkg::PhaseBits'($urandom_range(0, 2 << wtosc_pkg::FracBits));
      3: step = wtosc_pkg::PhaseBits'($urandom);
      default: step = wtosc_pkg::PhaseBits'($urandom_range(1 << 12,
                                                          3 << wtosc_pkg::FracBits));
    endcase
    case ($urandom_range(4))
      0: gain = '0;
      1: gain = '1;
      2: gain = wtosc_pkg::AmpReset;
      default: gain = wtosc_pkg::AmpBits'($urandom);
    endcase
    write_regs(step, gain);
  endtask

  task automatic random_words(int count);
    int stop, r, n;
    stop = sent_words + count;
    while (sent_words < stop) begin
      r = $urandom_range(99);
      if (r < 12) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
        load_table(n, ($urandom_range(3) == 0) ? wtosc_pkg::LenBits'($urandom_range(1, n))
                                               : wtosc_pkg::LenBits'(n));
        if ($urandom_range(2) == 0) phase_reset();
      end else if (r < 70) begin
        tick();
      end else if (r < 78) begin
        phase_reset();
      end else if (r < 86) begin
        commit(($urandom_range(1) == 0) ? wtosc_pkg::LenBits'($urandom)
                                        : wtosc_pkg::LenBits'($urandom_range(0, 8)));
      end else begin
        write_entry(wtosc_pkg::IdxBits'($urandom), pick_value());
      end
    end
  endtask

  initial begin
    osc = new();
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= wtosc_pkg::CMD_TICK;
    cfg_we_i <= 1'b0;
    cfg_index_i <= wtosc_pkg::CFG_PHASE_INC;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then a write that cancels a waiting commit
    tick();
    write_entry(11'd0, 16'h7FFF);
    write_entry(11'd1, 16'h8000);
    commit(12'd2);
    write_entry(11'd2, 16'h1234);
    tick();
    commit(12'd2);
    tick();
    settle();

    // half-step interpolation at full gain, wrap from the last entry to 0
    write_regs(27'h0008000, 16'hFFFF);
    repeat (4) tick();
    write_entry(11'd0, 16'h4000);
    write_entry(11'd1, 16'hC000);
    write_entry(11'd2046, 16'h8001);
    write_entry(11'd2047, 16'h7FFF);
    commit(12'hFFF);
    phase_reset();
    settle();

    // oversized commit length, then phase overflow at zero gain
    write_regs(27'h7FF8000, wtosc_pkg::AmpReset);
    repeat (3) tick();
    settle();
    write_regs('1, 16'h0000);
    repeat (2) tick();
    commit(12'd0);
    tick();
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 47;
          rx_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          rx_stall_pct = 47;
        end
        default: begin
          src_idle_pct = 11;
          rx_stall_pct = 11;
        end
      endcase
      random_config();
      if (ph == 0) begin
        load_table(8, 12'd8);
        rx_hold_req = 1'b1;
        repeat (20) tick();
      end
      random_words(165);
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (osc.errors == 0 && osc.samples_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
